// File: design/gfpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfpn_pkg: shared constants and types of the GF(p^n) multiplier
// Field sizes, configuration register indexes and the structs that travel
// between the cells of the multiplier chain.
// ----------------------------------------------------------------------------
package gfpn_pkg;

  localparam int MAX_DEGREE = 8;
  localparam int COEF_BITS  = 8;
  localparam int PRIME_BITS = 8;
  localparam int DEG_BITS   = 4;

  localparam int OPER_BITS = MAX_DEGREE * COEF_BITS;
  localparam int IDX_BITS  = $clog2(MAX_DEGREE);
  // barrett reduction of a PRIME_BITS x PRIME_BITS product
  localparam int RED_BITS  = 2 * PRIME_BITS;
  localparam int RES_BITS  = PRIME_BITS + 2;
  localparam int LANES     = 2 * MAX_DEGREE;
  localparam int CNT_BITS  = $clog2(RED_BITS + 1);

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRIME  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEGREE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLY   = 2'd2;

  localparam int PrimeResetInt = 5;
  localparam logic [PRIME_BITS-1:0] PRIME_RESET  = PRIME_BITS'(PrimeResetInt);
  localparam logic [DEG_BITS-1:0]   DEGREE_RESET = DEG_BITS'(2);
  localparam logic [OPER_BITS-1:0]  POLY_RESET   = OPER_BITS'(257);
  localparam logic [RED_BITS-1:0]   MU_RESET     =
    RED_BITS'((longint'(1) << RED_BITS) / PrimeResetInt);

  typedef logic [MAX_DEGREE-1:0][COEF_BITS-1:0]  coef_vec_t;
  typedef logic [MAX_DEGREE-1:0][PRIME_BITS-1:0] res_vec_t;

  typedef struct packed {
    logic [PRIME_BITS-1:0] prime;
    logic [RED_BITS-1:0]   mu;
    logic [DEG_BITS-1:0]   degree;
    coef_vec_t             poly;
  } cfg_t;

  typedef struct packed {
    coef_vec_t a;
    coef_vec_t b;
    res_vec_t  r;
  } cell_data_t;

endpackage

// File: design/gfpn_recip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfpn_recip: barrett reciprocal of the prime modulus
// Restoring divider, one quotient bit per cycle, producing floor(2^16 / p)
// after each write of the prime modulus.
// ----------------------------------------------------------------------------
module gfpn_recip (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [gfpn_pkg::PRIME_BITS-1:0] prime_i,
  output logic [gfpn_pkg::RED_BITS-1:0]   mu_o,
  output logic                            busy_o
);

  logic                            busy_q, busy_d;
  logic [gfpn_pkg::CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [gfpn_pkg::PRIME_BITS-1:0] rem_q, rem_d;
  logic [gfpn_pkg::RED_BITS:0]     quo_q, quo_d;
  logic [gfpn_pkg::RED_BITS-1:0]   mu_q, mu_d;
  logic [gfpn_pkg::PRIME_BITS:0]   rem_sh;
  logic                            num_bit;
  logic                            ge;

  // numerator is 2^16: only its top bit is set
  assign num_bit = (cnt_q == gfpn_pkg::CNT_BITS'(gfpn_pkg::RED_BITS));
  assign rem_sh  = {rem_q, num_bit};
  assign ge      = (rem_sh >= {1'b0, prime_i});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    mu_d   = mu_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = gfpn_pkg::CNT_BITS'(gfpn_pkg::RED_BITS);
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? gfpn_pkg::PRIME_BITS'(rem_sh - {1'b0, prime_i})
                 : rem_sh[gfpn_pkg::PRIME_BITS-1:0];
      quo_d = {quo_q[gfpn_pkg::RED_BITS-1:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        mu_d   = quo_d[gfpn_pkg::RED_BITS-1:0];
      end else begin
        cnt_d = cnt_q - gfpn_pkg::CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      mu_q   <= gfpn_pkg::MU_RESET;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      mu_q   <= mu_d;
    end
  end

  assign mu_o   = mu_q;
  assign busy_o = busy_q;

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("reciprocal did not start");

  a_done_at_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> ($past(cnt_q) == '0) || $past(start_i))
    else $error("reciprocal finished early");

endmodule

// File: design/gfpn_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfpn_cell: one horner step of the field multiplier
// Computes r = x*r mod M + a_top*b with coefficients mod p, over five
// stages: products, barrett estimate, remainder, correction, combine.
// ----------------------------------------------------------------------------
module gfpn_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gfpn_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gfpn_pkg::cell_data_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output gfpn_pkg::cell_data_t out_data_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_q || out_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // stage 1: lane j < MAX_DEGREE holds a_top*b[j], the rest q*m[j]
  logic [gfpn_pkg::COEF_BITS-1:0]  a_top;
  logic [gfpn_pkg::PRIME_BITS-1:0] q;
  logic [gfpn_pkg::DEG_BITS-1:0]   deg_m1;
  logic [gfpn_pkg::RED_BITS-1:0]   t1_d [gfpn_pkg::LANES];
  gfpn_pkg::res_vec_t              rs1_d;
  gfpn_pkg::coef_vec_t             a1_d;

  assign a_top  = in_data_i.a[gfpn_pkg::MAX_DEGREE-1];
  assign deg_m1 = cfg_i.degree - gfpn_pkg::DEG_BITS'(1);
  assign q      = (cfg_i.degree == '0) ? '0 : in_data_i.r[deg_m1[gfpn_pkg::IDX_BITS-1:0]];
  assign a1_d   = gfpn_pkg::coef_vec_t'(in_data_i.a << gfpn_pkg::COEF_BITS);

  always_comb begin
    rs1_d[0] = '0;
    for (int j = 1; j < gfpn_pkg::MAX_DEGREE; j++) begin
      rs1_d[j] = (gfpn_pkg::DEG_BITS'(j) < cfg_i.degree) ? in_data_i.r[j-1] : '0;
    end
    for (int j = 0; j < gfpn_pkg::MAX_DEGREE; j++) begin
      t1_d[j] = gfpn_pkg::RED_BITS'(a_top) * gfpn_pkg::RED_BITS'(in_data_i.b[j]);
      t1_d[gfpn_pkg::MAX_DEGREE+j] =
        gfpn_pkg::RED_BITS'(q) * gfpn_pkg::RED_BITS'(cfg_i.poly[j]);
    end
  end

  logic [gfpn_pkg::RED_BITS-1:0] t1_q [gfpn_pkg::LANES];
  gfpn_pkg::res_vec_t            rs1_q, rs2_q, rs3_q, rs4_q;
  gfpn_pkg::coef_vec_t           a1_q, a2_q, a3_q, a4_q, a5_q;
  gfpn_pkg::coef_vec_t           b1_q, b2_q, b3_q, b4_q, b5_q;

  // stage 2: quotient estimate from the reciprocal
  logic [2*gfpn_pkg::RED_BITS-1:0] wide [gfpn_pkg::LANES];
  logic [gfpn_pkg::RED_BITS-1:0]   qh2_d [gfpn_pkg::LANES];
  logic [gfpn_pkg::RED_BITS-1:0]   qh2_q [gfpn_pkg::LANES];
  logic [gfpn_pkg::RED_BITS-1:0]   t2_q  [gfpn_pkg::LANES];

  always_comb begin
    for (int l = 0; l < gfpn_pkg::LANES; l++) begin
      wide[l]  = (2*gfpn_pkg::RED_BITS)'(t1_q[l]) * (2*gfpn_pkg::RED_BITS)'(cfg_i.mu);
      qh2_d[l] = wide[l][2*gfpn_pkg::RED_BITS-1:gfpn_pkg::RED_BITS];
    end
  end

  // stage 3: remainder below 3p, exact in the low bits
  logic [gfpn_pkg::RED_BITS-1:0] qp   [gfpn_pkg::LANES];
  logic [gfpn_pkg::RED_BITS-1:0] dif  [gfpn_pkg::LANES];
  logic [gfpn_pkg::RES_BITS-1:0] d3_d [gfpn_pkg::LANES];
  logic [gfpn_pkg::RES_BITS-1:0] d3_q [gfpn_pkg::LANES];

  always_comb begin
    for (int l = 0; l < gfpn_pkg::LANES; l++) begin
      qp[l]   = qh2_q[l] * gfpn_pkg::RED_BITS'(cfg_i.prime);
      dif[l]  = t2_q[l] - qp[l];
      d3_d[l] = dif[l][gfpn_pkg::RES_BITS-1:0];
    end
  end

  // stage 4: two corrections bring each lane into 0..p-1
  logic [gfpn_pkg::RES_BITS-1:0]   pw;
  logic [gfpn_pkg::RES_BITS-1:0]   c1 [gfpn_pkg::LANES];
  logic [gfpn_pkg::RES_BITS-1:0]   c2 [gfpn_pkg::LANES];
  logic [gfpn_pkg::PRIME_BITS-1:0] red4_d [gfpn_pkg::LANES];
  logic [gfpn_pkg::PRIME_BITS-1:0] red4_q [gfpn_pkg::LANES];

  assign pw = gfpn_pkg::RES_BITS'(cfg_i.prime);

  always_comb begin
    for (int l = 0; l < gfpn_pkg::LANES; l++) begin
      c1[l]     = (d3_q[l] >= pw) ? d3_q[l] - pw : d3_q[l];
      c2[l]     = (c1[l] >= pw) ? c1[l] - pw : c1[l];
      red4_d[l] = c2[l][gfpn_pkg::PRIME_BITS-1:0];
    end
  end

  // stage 5: r[j] = r[j-1] + a_top*b[j] - q*m[j] mod p
  logic [gfpn_pkg::PRIME_BITS:0] pw1;
  logic [gfpn_pkg::PRIME_BITS:0] sum;
  logic [gfpn_pkg::PRIME_BITS:0] qm1;
  logic [gfpn_pkg::PRIME_BITS:0] nr;
  gfpn_pkg::res_vec_t            r5_d;
  gfpn_pkg::res_vec_t            r5_q;

  assign pw1 = {1'b0, cfg_i.prime};

  always_comb begin
    sum = '0;
    qm1 = '0;
    nr  = '0;
    for (int j = 0; j < gfpn_pkg::MAX_DEGREE; j++) begin
      sum = {1'b0, rs4_q[j]} + {1'b0, red4_q[j]};
      if (sum >= pw1) sum = sum - pw1;
      qm1 = {1'b0, red4_q[gfpn_pkg::MAX_DEGREE+j]};
      nr  = (sum >= qm1) ? sum - qm1 : sum + pw1 - qm1;
      r5_d[j] = nr[gfpn_pkg::PRIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      t1_q  <= t1_d;
      rs1_q <= rs1_d;
      a1_q  <= a1_d;
      b1_q  <= in_data_i.b;
    end
    if (rdy2) begin
      qh2_q <= qh2_d;
      t2_q  <= t1_q;
      rs2_q <= rs1_q;
      a2_q  <= a1_q;
      b2_q  <= b1_q;
    end
    if (rdy3) begin
      d3_q  <= d3_d;
      rs3_q <= rs2_q;
      a3_q  <= a2_q;
      b3_q  <= b2_q;
    end
    if (rdy4) begin
      red4_q <= red4_d;
      rs4_q  <= rs3_q;
      a4_q   <= a3_q;
      b4_q   <= b3_q;
    end
    if (rdy5) begin
      r5_q <= r5_d;
      a5_q <= a4_q;
      b5_q <= b4_q;
    end
  end

  assign out_valid_o  = v5_q;
  assign out_data_o.a = a5_q;
  assign out_data_o.b = b5_q;
  assign out_data_o.r = r5_q;

  a_last_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && !out_ready_i |=> v5_q)
    else $error("stalled result lost in cell");

endmodule

// File: design/gf_pn_multiplier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf_pn_multiplier_top: GF(p^n) multiplier stream block
// Multiplies two packed field elements modulo a monic polynomial of degree n
// with coefficients reduced modulo p, through a chain of horner cells.
// ----------------------------------------------------------------------------
// One request enters per clock while neither backpressure nor the reciprocal
// holds the input; the chain has one cell per coefficient (8), each five
// register stages deep (coefficient products, barrett estimate, remainder,
// correction, combine). Every lane holds its result under output backpressure
// while bubbles in the chain keep taking new requests. Writing prime_modulus
// starts a bit-serial reciprocal, and s_axis_tready is low while it runs.
// A prime modulus below two gives a zero product.
module gf_pn_multiplier_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // operand_a [63:0], operand_b [127:64]
  input  logic [2*gfpn_pkg::OPER_BITS-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // product [63:0]
  output logic [gfpn_pkg::OPER_BITS-1:0]    m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [gfpn_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [gfpn_pkg::OPER_BITS-1:0]    cfg_wdata_i
);

  logic [gfpn_pkg::PRIME_BITS-1:0] prime_q;
  logic [gfpn_pkg::DEG_BITS-1:0]   degree_q;
  logic [gfpn_pkg::OPER_BITS-1:0]  poly_q;
  logic                            prime_wr;

  always_comb begin
    prime_wr = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gfpn_pkg::CFG_PRIME:  prime_wr = 1'b1;
        default:              prime_wr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q  <= gfpn_pkg::PRIME_RESET;
      degree_q <= gfpn_pkg::DEGREE_RESET;
      poly_q   <= gfpn_pkg::POLY_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gfpn_pkg::CFG_PRIME:  prime_q  <= cfg_wdata_i[gfpn_pkg::PRIME_BITS-1:0];
        gfpn_pkg::CFG_DEGREE: degree_q <= cfg_wdata_i[gfpn_pkg::DEG_BITS-1:0];
        gfpn_pkg::CFG_POLY:   poly_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [gfpn_pkg::RED_BITS-1:0] mu;
  logic                          busy;

  gfpn_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (prime_wr),
    .prime_i (prime_q),
    .mu_o    (mu),
    .busy_o  (busy)
  );

  // degree saturates, coefficients at or above it are dropped
  logic [gfpn_pkg::DEG_BITS-1:0] deg_eff;
  gfpn_pkg::coef_vec_t           a_in, b_in, poly_in;
  gfpn_pkg::cfg_t                cfg;

  assign deg_eff = (degree_q > gfpn_pkg::DEG_BITS'(gfpn_pkg::MAX_DEGREE))
                   ? gfpn_pkg::DEG_BITS'(gfpn_pkg::MAX_DEGREE) : degree_q;

  always_comb begin
    a_in    = gfpn_pkg::coef_vec_t'(s_axis_tdata[gfpn_pkg::OPER_BITS-1:0]);
    b_in    = gfpn_pkg::coef_vec_t'(s_axis_tdata[2*gfpn_pkg::OPER_BITS-1:gfpn_pkg::OPER_BITS]);
    poly_in = gfpn_pkg::coef_vec_t'(poly_q);
    for (int j = 0; j < gfpn_pkg::MAX_DEGREE; j++) begin
      if (gfpn_pkg::DEG_BITS'(j) >= deg_eff) begin
        a_in[j]    = '0;
        b_in[j]    = '0;
        poly_in[j] = '0;
      end
    end
  end

  assign cfg.prime  = prime_q;
  assign cfg.mu     = mu;
  assign cfg.degree = deg_eff;
  assign cfg.poly   = poly_in;

  logic [gfpn_pkg::MAX_DEGREE:0] chain_valid;
  logic [gfpn_pkg::MAX_DEGREE:0] chain_ready;
  gfpn_pkg::cell_data_t          chain_data [gfpn_pkg::MAX_DEGREE+1];

  assign chain_valid[0]  = s_axis_tvalid && !busy;
  assign s_axis_tready   = chain_ready[0] && !busy;
  assign chain_data[0].a = a_in;
  assign chain_data[0].b = b_in;
  assign chain_data[0].r = '0;

  for (genvar k = 0; k < gfpn_pkg::MAX_DEGREE; k++) begin : g_cell
    gfpn_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (cfg),
      .in_valid_i  (chain_valid[k]),
      .in_ready_o  (chain_ready[k]),
      .in_data_i   (chain_data[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_ready_i (chain_ready[k+1]),
      .out_data_o  (chain_data[k+1])
    );
  end

  logic prime_small;
  assign prime_small = (prime_q < gfpn_pkg::PRIME_BITS'(2));

  assign m_axis_tvalid = chain_valid[gfpn_pkg::MAX_DEGREE];
  assign chain_ready[gfpn_pkg::MAX_DEGREE] = m_axis_tready;

  always_comb begin
    for (int j = 0; j < gfpn_pkg::MAX_DEGREE; j++) begin
      m_axis_tdata[gfpn_pkg::COEF_BITS*j +: gfpn_pkg::COEF_BITS] = prime_small ? '0 :
        chain_data[gfpn_pkg::MAX_DEGREE].r[j][gfpn_pkg::COEF_BITS-1:0];
    end
  end

  a_busy_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready)
    else $error("request taken while reciprocal runs");

endmodule
